// ===== src/activity_selection_scheduler_macros.svh =====
// Assertion macros for the activity selection scheduler.
`ifndef ACTIVITY_SELECTION_SCHEDULER_MACROS_SVH
`define ACTIVITY_SELECTION_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define ASC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler assertion failed");
`define ASC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("scheduler reset assertion failed");
`else
`define ASC_ASSERT(lbl, prop)
`define ASC_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/asc_pkg.sv =====
// Shared types and constants of the activity selection scheduler.
package asc_pkg;
  localparam int unsigned OutFieldW = 7;

  typedef enum logic [1:0] {
    StLoad,
    StScan
  } state_e;

  typedef struct packed {
    logic insert;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic out_free;
    logic pend_valid;
  } sts_t;
endpackage

// ===== src/activity_selection_scheduler.sv =====
// Top level of the greedy activity selection scheduler.
// Intervals arrive on the slave stream, one request each: tdata holds the
// start time in the low TIME_BITS bits and the end time above it, tlast
// marks the final interval of a set. Each interval is numbered from 1 in
// arrival order and inserted at its sorted place in a chain of cells, and
// the slave side stays ready while loading; intervals beyond MAX_INTERVALS
// are dropped, though their tlast still closes the set. After the last
// interval the chain is scanned one cell per cycle while the master side
// has room, and each selected interval leaves on the master stream as its
// arrival number and running count, tlast on the final one. The scan steps
// once per stored cell and then releases the final result, after which the
// slave side is ready again. The slave side is not ready during the scan.
// A stalled master side holds the output register and pauses the scan.
// Reset empties the set and leaves the block ready for loading.
module activity_selection_scheduler #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [TIME_BITS-1:0] start_time, [2*TIME_BITS-1:TIME_BITS] end_time, zero pad
  input  logic [((2*TIME_BITS+7)/8)*8-1:0]         s_axis_tdata,
  input  logic                                     s_axis_tlast,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // [6:0] meeting_number, [13:7] selected_count, [15:14] zero
  output logic [15:0]                              m_axis_tdata,
  output logic                                     m_axis_tlast
);
  import asc_pkg::*;
  `include "activity_selection_scheduler_macros.svh"

  cmd_t cmd;
  sts_t sts;
  logic [OutFieldW-1:0] number, count;

  asc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  asc_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_start_i   (s_axis_tdata[TIME_BITS-1:0]),
    .in_end_i     (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_number_o (number),
    .out_count_o  (count),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, count, number};

  `ASC_ASSERT(a_step_needs_room, (cmd.step || cmd.flush) |-> sts.out_free)
  `ASC_ASSERT(a_flush_has_pending, cmd.flush |-> sts.pend_valid)
  `ASC_ASSERT(a_load_no_pending, s_axis_tready |-> !sts.pend_valid)
  `ASC_ASSERT_RST(a_reset_ready, !rst_ni |=> s_axis_tready || !rst_ni)
endmodule

// ===== src/asc_ctrl.sv =====
// Controller state machine: loading intervals, then scanning the sorted chain.
module asc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  asc_pkg::sts_t sts_i,
  output asc_pkg::cmd_t cmd_o
);
  import asc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad: begin
        if (in_valid_i && in_last_i) state_d = StScan;
      end
      StScan: begin
        if (sts_i.out_free && sts_i.rem_zero) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o   = 1'b1;
        cmd_o.insert = in_valid_i;
      end
      StScan: begin
        cmd_o.step  = sts_i.out_free && !sts_i.rem_zero;
        cmd_o.flush = sts_i.out_free && sts_i.rem_zero;
      end
      default: ;
    endcase
  end
endmodule

// ===== src/asc_dp.sv =====
// Datapath: sorted insertion chain of cells, greedy selection and output register.
module asc_dp #(
  parameter int unsigned MAX_INTERVALS = 64,
  parameter int unsigned TIME_BITS     = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  asc_pkg::cmd_t              cmd_i,
  output asc_pkg::sts_t              sts_o,
  input  logic [TIME_BITS-1:0]       in_start_i,
  input  logic [TIME_BITS-1:0]       in_end_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [asc_pkg::OutFieldW-1:0] out_number_o,
  output logic [asc_pkg::OutFieldW-1:0] out_count_o,
  output logic                       out_last_o
);
  import asc_pkg::*;

  localparam int unsigned NumW = $clog2(MAX_INTERVALS);
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);

  logic [TIME_BITS-1:0] start_q [MAX_INTERVALS];
  logic [TIME_BITS-1:0] end_q   [MAX_INTERVALS];
  logic [NumW-1:0]      num_q   [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] ge;

  logic [CntW-1:0] count_q, rem_q;
  logic            full;
  logic            first_q, pend_valid_q, out_valid_q, out_last_q;
  logic [TIME_BITS-1:0] last_end_q;
  logic [OutFieldW-1:0] pend_num_q, pend_cnt_q, sel_cnt_q, out_num_q, out_cnt_q;
  logic            sel;

  assign full = (count_q == CntW'(MAX_INTERVALS));

  // A stored cell at or below the new end keeps its place; the new one goes after it.
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      ge[i] = (CntW'(i) < count_q) && (end_q[i] <= in_end_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      if (cmd_i.insert && !full) begin
        if (!ge[i] && (i == 0 || ge[(i > 0) ? i - 1 : 0])) begin
          start_q[i] <= in_start_i;
          end_q[i]   <= in_end_i;
          num_q[i]   <= count_q[NumW-1:0];
        end else if (!ge[i] && i > 0) begin
          start_q[i] <= start_q[(i > 0) ? i - 1 : 0];
          end_q[i]   <= end_q[(i > 0) ? i - 1 : 0];
          num_q[i]   <= num_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.step && i < MAX_INTERVALS - 1) begin
        start_q[i] <= start_q[(i < MAX_INTERVALS - 1) ? i + 1 : i];
        end_q[i]   <= end_q[(i < MAX_INTERVALS - 1) ? i + 1 : i];
        num_q[i]   <= num_q[(i < MAX_INTERVALS - 1) ? i + 1 : i];
      end
    end
  end

  assign sel = first_q || (start_q[0] > last_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rem_q        <= '0;
      first_q      <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      last_end_q   <= '0;
      sel_cnt_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.insert) begin
        if (!full) count_q <= count_q + 1'b1;
        if (in_last_i) rem_q <= full ? count_q : count_q + 1'b1;
      end
      if (cmd_i.step) begin
        rem_q <= rem_q - 1'b1;
        if (sel) begin
          first_q      <= 1'b0;
          last_end_q   <= end_q[0];
          pend_valid_q <= 1'b1;
          sel_cnt_q    <= sel_cnt_q + 1'b1;
          if (pend_valid_q) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b0;
          end
        end
      end
      if (cmd_i.flush) begin
        out_valid_q  <= 1'b1;
        out_last_q   <= 1'b1;
        pend_valid_q <= 1'b0;
        first_q      <= 1'b1;
        sel_cnt_q    <= '0;
        count_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && sel) begin
      pend_num_q <= OutFieldW'(num_q[0]) + 1'b1;
      pend_cnt_q <= sel_cnt_q + 1'b1;
      if (pend_valid_q) begin
        out_num_q <= pend_num_q;
        out_cnt_q <= pend_cnt_q;
      end
    end
    if (cmd_i.flush) begin
      out_num_q <= pend_num_q;
      out_cnt_q <= pend_cnt_q;
    end
  end

  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.pend_valid = pend_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_number_o = out_num_q;
  assign out_count_o  = out_cnt_q;
  assign out_last_o   = out_last_q;
endmodule

// ===== tb/activity_selection_scheduler_tb.sv =====
// Self-checking testbench for the greedy activity selection scheduler.
module activity_selection_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxIv = 64;
  localparam int unsigned TimeW = 16;

  typedef struct packed {
    logic [6:0] meeting;
    logic [6:0] count;
    logic       fin;
  } pick_t;

  typedef struct {
    logic [15:0] st;
    logic [15:0] en;
    logic        lst;
  } iv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;

  activity_selection_scheduler #(.MAX_INTERVALS(MaxIv), .TIME_BITS(TimeW)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Predictor state: the set being loaded and the end of the last pick.
  logic [15:0] set_starts[MaxIv];
  logic [15:0] set_ends[MaxIv];
  int unsigned set_size = 0;
  logic [15:0] last_pick_end = '0;

  pick_t picks_due[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned sets_closed = 0;
  int unsigned hold_cycles = 0;
  bit long_hold = 1'b0;

  task automatic schedule_set(input logic [15:0] st, input logic [15:0] en, input logic lst);
    int unsigned order[MaxIv];
    int unsigned j, cur, n;
    pick_t p;
    if (set_size < MaxIv) begin
      set_starts[set_size] = st;
      set_ends[set_size] = en;
      set_size++;
    end
    if (!lst || set_size == 0) return;
    for (int i = 0; i < set_size; i++) order[i] = i;
    for (int i = 1; i < set_size; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && set_ends[order[j-1]] > set_ends[cur]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    n = 0;
    for (int i = 0; i < set_size; i++) begin
      if (i == 0 || set_starts[order[i]] > last_pick_end) begin
        last_pick_end = set_ends[order[i]];
        n++;
        p.meeting = 7'(order[i] + 1);
        p.count = 7'(n);
        p.fin = 1'b0;
        picks_due.insert(picks_due.size(), p);
      end
    end
    picks_due[picks_due.size()-1].fin = 1'b1;
    set_size = 0;
    sets_closed++;
  endtask

  // Receiver: stalls on its own pattern, with one long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold && results_seen > 20) begin
        long_hold <= 1'b1;
        hold_cycles <= 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (results_seen / 50) % 2 == 1 ? 1'b1 : ($urandom_range(3) != 0);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (picks_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          pick_t exp_p;
          exp_p = picks_due.pop_front();
          if (m_axis_tdata[6:0] !== exp_p.meeting || m_axis_tdata[13:7] !== exp_p.count ||
              m_axis_tdata[15:14] !== 2'b00 || m_axis_tlast !== exp_p.fin) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp num %0d cnt %0d last %b, got num %0d cnt %0d last %b",
                       exp_p.meeting, exp_p.count, exp_p.fin, m_axis_tdata[6:0],
                       m_axis_tdata[13:7], m_axis_tlast);
          end
        end
      end
    end
  end

  task automatic send_interval(input iv_t iv, input bit gaps);
    if (gaps && $urandom_range(5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {iv.en, iv.st};
    s_axis_tlast <= iv.lst;
    do @(posedge clk_i); while (!s_axis_tready);
    schedule_set(iv.st, iv.en, iv.lst);
  endtask

  iv_t directed[] = '{
    '{16'd0, 16'd0, 1'b1},
    '{16'hFFFF, 16'hFFFF, 1'b1},
    '{16'd1, 16'd5, 1'b0}, '{16'd5, 16'd9, 1'b0}, '{16'd6, 16'd9, 1'b0},
    '{16'd10, 16'd12, 1'b1},
    '{16'd3, 16'd7, 1'b0}, '{16'd2, 16'd7, 1'b0}, '{16'd0, 16'd2, 1'b1},
    '{16'hAAAA, 16'h5555, 1'b0}, '{16'h5555, 16'hAAAA, 1'b0},
    '{16'hFFFF, 16'h0000, 1'b1}
  };

  initial begin
    iv_t iv;
    int unsigned sent, len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[k]) send_interval(directed[k], 1'b0);
    // Full set plus overflow items; the closing one is dropped but ends the set.
    for (int k = 0; k < 70; k++) begin
      iv.st = 16'($urandom); iv.en = 16'($urandom); iv.lst = (k == 69);
      send_interval(iv, 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    sent = 0;
    while (sent < 280) begin
      len = $urandom_range(12) == 0 ? $urandom_range(40, 64) : $urandom_range(1, 10);
      if (len > 280 - sent) len = 280 - sent;
      for (int k = 0; k < len; k++) begin
        iv.st = 16'($urandom_range(0, 1000));
        iv.en = iv.st + 16'($urandom_range(0, 200));
        if ($urandom_range(9) == 0) begin
          iv.st = 16'($urandom); iv.en = 16'($urandom);
        end
        iv.lst = (k == len - 1);
        send_interval(iv, 1'b1);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d sets, %0d selected intervals, including overflow and tie cases",
             sets_closed, results_seen);
    if (errors == 0 && picks_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
